// ----- design/power_meter_frame_parser_macros.svh -----
// Assertion macros used by the power meter frame parser checker
`ifndef POWER_METER_FRAME_PARSER_MACROS_SVH
`define POWER_METER_FRAME_PARSER_MACROS_SVH

// Property must hold at every edge outside reset
`define PMFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge
`define PMFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/pmfp_pkg.sv -----
// Types, constants and codes of the power meter frame parser
`default_nettype none

package pmfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int COEFF_W     = 24;
    localparam int WORD_W      = 24;
    localparam int VALUE_W     = 48;
    localparam int STATUS_W    = 2;
    localparam int FLAGS_W     = 3;
    localparam int FLAG_LSB    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int WORD_COUNT  = 6;
    localparam int WORD_BYTES  = 18;

    localparam int FRAME_BYTES = 24;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_HUNT      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FIRST     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST_WORD = POS_W'(19);
    localparam logic [POS_W-1:0] POS_FLAG      = POS_W'(20);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h5A;
    localparam logic [BYTE_W-1:0] HDR_A       = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_B       = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_NIB_MSK = 8'hF0;

    localparam logic [COEFF_W-1:0] VOLTAGE_COEFF_RST = 24'd123208;
    localparam logic [COEFF_W-1:0] CURRENT_COEFF_RST = 24'd65536;
    localparam logic [COEFF_W-1:0] POWER_COEFF_RST   = 24'd123208;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_WAIT
    } t_seq_state;

    typedef enum logic [1:0] {
        QTY_VOLTAGE,
        QTY_CURRENT,
        QTY_POWER
    } t_qty;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_STEP
    } t_div_state;

    typedef struct packed {
        logic               last;
        logic               sum_ok;
        logic [BYTE_W-1:0]  header;
        logic [FLAGS_W-1:0] flags;
    } t_frame_info;

    typedef struct packed {
        logic               start;
        logic [COEFF_W-1:0] coeff;
        logic [WORD_W-1:0]  param;
        logic [WORD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic [VALUE_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- design/power_meter_frame_parser.sv -----
// Power meter frame parser: hunts 24-byte meter frames on a byte stream, checks the sum of
// bytes 2 to 22 against byte 23 and scales voltage, current and power as
// coefficient * parameter / register in unsigned fixed point. Bytes are taken while the
// parser is idle. When the last byte of a frame whose checksum matches is taken, it starts
// three quantities in turn on one shared unit (one multiply step, then 48 restoring divide
// steps at one quotient bit per cycle, or a saturated result when the divisor is zero), and
// further bytes are held off until all three are done. The result beat waits in an output
// register while further bytes are taken; besides that, a frame's last byte is held off
// while that register is still full and stalled. Coefficients are written over the plain
// write port; the user must do so only while idle, which the block does not enforce.
`default_nettype none

module power_meter_frame_parser (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [pmfp_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [pmfp_pkg::STATUS_W-1:0]            o_frame_status,
    output logic [pmfp_pkg::BYTE_W-1:0]              o_chip_state,
    output logic [pmfp_pkg::FLAGS_W-1:0]             o_update_flags,
    output logic [pmfp_pkg::VALUE_W-1:0]             o_voltage_value,
    output logic [pmfp_pkg::VALUE_W-1:0]             o_current_value,
    output logic [pmfp_pkg::VALUE_W-1:0]             o_power_value,
    input  wire logic                                i_cfg_we,
    input  wire logic [pmfp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [pmfp_pkg::COEFF_W-1:0]        i_cfg_data
);

    pmfp_pkg::t_seq_state r_state, n_state;
    pmfp_pkg::t_qty       r_qty,   n_qty;
    logic                 r_zero,  n_zero;
    logic                 r_out_valid, n_out_valid;
    logic [pmfp_pkg::STATUS_W-1:0] r_status, n_status;
    logic [pmfp_pkg::BYTE_W-1:0]   r_chip,   n_chip;
    logic [pmfp_pkg::FLAGS_W-1:0]  r_flags,  n_flags;
    logic [pmfp_pkg::VALUE_W-1:0]  r_volt,   n_volt;
    logic [pmfp_pkg::VALUE_W-1:0]  r_curr,   n_curr;
    logic [pmfp_pkg::VALUE_W-1:0]  r_pow,    n_pow;
    logic [pmfp_pkg::COEFF_W-1:0]  r_vcoeff, r_ccoeff, r_pcoeff;

    pmfp_pkg::t_frame_info info;
    pmfp_pkg::t_div_req    div_req;
    pmfp_pkg::t_div_rsp    div_rsp;
    logic [pmfp_pkg::WORD_COUNT-1:0][pmfp_pkg::WORD_W-1:0] words;
    logic                  in_take;
    logic                  out_take;

    assign o_in_stall = (r_state != pmfp_pkg::SEQ_IDLE)
                     || (info.last && r_out_valid && i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    pmfp_collect u_collect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_take),
        .i_byte   (i_rx_byte),
        .o_info   (info),
        .o_words  (words)
    );

    pmfp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcoeff <= pmfp_pkg::VOLTAGE_COEFF_RST;
            r_ccoeff <= pmfp_pkg::CURRENT_COEFF_RST;
            r_pcoeff <= pmfp_pkg::POWER_COEFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmfp_pkg::CFG_VOLTAGE: r_vcoeff <= i_cfg_data;
                pmfp_pkg::CFG_CURRENT: r_ccoeff <= i_cfg_data;
                pmfp_pkg::CFG_POWER:   r_pcoeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for the shared unit
    always_comb begin
        div_req.start = (r_state == pmfp_pkg::SEQ_START);
        unique case (r_qty)
            pmfp_pkg::QTY_VOLTAGE: begin
                div_req.coeff   = r_vcoeff;
                div_req.param   = words[0];
                div_req.divisor = words[1];
            end
            pmfp_pkg::QTY_CURRENT: begin
                div_req.coeff   = r_ccoeff;
                div_req.param   = words[2];
                div_req.divisor = words[3];
            end
            default: begin
                div_req.coeff   = r_pcoeff;
                div_req.param   = words[4];
                div_req.divisor = words[5];
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_qty       = r_qty;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !out_take;
        n_status    = r_status;
        n_chip      = r_chip;
        n_flags     = r_flags;
        n_volt      = r_volt;
        n_curr      = r_curr;
        n_pow       = r_pow;
        unique case (r_state)
            pmfp_pkg::SEQ_IDLE: begin
                if (in_take && info.last) begin
                    n_chip  = info.header;
                    n_flags = info.flags;
                    if (!info.sum_ok) begin
                        n_status    = pmfp_pkg::STATUS_BAD_SUM;
                        n_volt      = '0;
                        n_curr      = '0;
                        n_pow       = '0;
                        n_out_valid = 1'b1;
                    end else begin
                        n_zero  = 1'b0;
                        n_qty   = pmfp_pkg::QTY_VOLTAGE;
                        n_state = pmfp_pkg::SEQ_START;
                    end
                end
            end
            pmfp_pkg::SEQ_START: begin
                n_state = pmfp_pkg::SEQ_WAIT;
            end
            pmfp_pkg::SEQ_WAIT: begin
                if (div_rsp.done) begin
                    n_zero = r_zero || div_rsp.zero;
                    unique case (r_qty)
                        pmfp_pkg::QTY_VOLTAGE: begin
                            n_volt  = div_rsp.quotient;
                            n_qty   = pmfp_pkg::QTY_CURRENT;
                            n_state = pmfp_pkg::SEQ_START;
                        end
                        pmfp_pkg::QTY_CURRENT: begin
                            n_curr  = div_rsp.quotient;
                            n_qty   = pmfp_pkg::QTY_POWER;
                            n_state = pmfp_pkg::SEQ_START;
                        end
                        default: begin
                            n_pow       = div_rsp.quotient;
                            n_status    = (r_zero || div_rsp.zero) ? pmfp_pkg::STATUS_ZERO_DIV
                                                                   : pmfp_pkg::STATUS_GOOD;
                            n_out_valid = 1'b1;
                            n_state     = pmfp_pkg::SEQ_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = pmfp_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmfp_pkg::SEQ_IDLE;
            r_qty       <= pmfp_pkg::QTY_VOLTAGE;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qty       <= n_qty;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_chip   <= n_chip;
        r_flags  <= n_flags;
        r_volt   <= n_volt;
        r_curr   <= n_curr;
        r_pow    <= n_pow;
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_status  = r_status;
    assign o_chip_state    = r_chip;
    assign o_update_flags  = r_flags;
    assign o_voltage_value = r_volt;
    assign o_current_value = r_curr;
    assign o_power_value   = r_pow;

endmodule

`default_nettype wire

// ----- design/pmfp_collect.sv -----
// Frame hunter and collector: header search, checksum, word shift line
`default_nettype none

module pmfp_collect (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_accept,
    input  wire logic [pmfp_pkg::BYTE_W-1:0]                  i_byte,
    output pmfp_pkg::t_frame_info                             o_info,
    output logic [pmfp_pkg::WORD_COUNT-1:0][pmfp_pkg::WORD_W-1:0] o_words
);

    logic [pmfp_pkg::POS_W-1:0]  r_pos,    n_pos;
    logic [pmfp_pkg::BYTE_W-1:0] r_prev,   n_prev;
    logic [pmfp_pkg::BYTE_W-1:0] r_sum,    n_sum;
    logic [pmfp_pkg::BYTE_W-1:0] r_header, n_header;
    logic [pmfp_pkg::BYTE_W-1:0] r_flag,   n_flag;
    logic [pmfp_pkg::WORD_BYTES-1:0][pmfp_pkg::BYTE_W-1:0] r_field, n_field;
    logic                        prev_is_header;

    assign prev_is_header = ((r_prev & pmfp_pkg::HDR_NIB_MSK) == pmfp_pkg::HDR_NIB_MSK)
                         || (r_prev == pmfp_pkg::HDR_A) || (r_prev == pmfp_pkg::HDR_B);

    always_comb begin
        n_pos    = r_pos;
        n_prev   = r_prev;
        n_sum    = r_sum;
        n_header = r_header;
        n_flag   = r_flag;
        n_field  = r_field;
        if (i_accept) begin
            n_prev = i_byte;
            priority if (r_pos == pmfp_pkg::POS_HUNT) begin
                if ((i_byte == pmfp_pkg::SYNC_BYTE) && prev_is_header) begin
                    n_header = r_prev;
                    n_sum    = '0;
                    n_pos    = pmfp_pkg::POS_FIRST;
                end
            end else if (r_pos == pmfp_pkg::POS_LAST) begin
                n_pos = pmfp_pkg::POS_HUNT;
            end else begin
                n_sum = r_sum + i_byte;
                if (r_pos <= pmfp_pkg::POS_LAST_WORD) begin
                    n_field = {r_field[pmfp_pkg::WORD_BYTES-2:0], i_byte};
                end else if (r_pos == pmfp_pkg::POS_FLAG) begin
                    n_flag = i_byte;
                end
                n_pos = r_pos + pmfp_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= pmfp_pkg::POS_HUNT;
            r_prev   <= '0;
            r_sum    <= '0;
            r_header <= '0;
            r_flag   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_prev   <= n_prev;
            r_sum    <= n_sum;
            r_header <= n_header;
            r_flag   <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field <= n_field;
    end

    // oldest byte sits at the top of the shift line
    always_comb begin
        for (int k = 0; k < pmfp_pkg::WORD_COUNT; k++) begin
            o_words[k] = {r_field[pmfp_pkg::WORD_BYTES-1-3*k],
                          r_field[pmfp_pkg::WORD_BYTES-2-3*k],
                          r_field[pmfp_pkg::WORD_BYTES-3-3*k]};
        end
    end

    assign o_info.last   = (r_pos == pmfp_pkg::POS_LAST);
    assign o_info.sum_ok = (r_sum == i_byte);
    assign o_info.header = r_header;
    assign o_info.flags  = r_flag[pmfp_pkg::FLAG_LSB +: pmfp_pkg::FLAGS_W];

endmodule

`default_nettype wire

// ----- design/pmfp_divider.sv -----
// Shared scaling unit: one multiply, then a bit-serial restoring divide (saturates on a zero divisor)
`default_nettype none

module pmfp_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pmfp_pkg::t_div_req i_req,
    output pmfp_pkg::t_div_rsp     o_rsp
);

    pmfp_pkg::t_div_state            r_state, n_state;
    logic [pmfp_pkg::DIV_CNT_W-1:0]  r_cnt,   n_cnt;
    logic                            r_done,  n_done;
    logic                            r_zero,  n_zero;
    logic [pmfp_pkg::VALUE_W-1:0]    r_quo,   n_quo;
    logic [pmfp_pkg::WORD_W-1:0]     r_rem,   n_rem;
    logic [pmfp_pkg::WORD_W-1:0]     r_div,   n_div;
    logic [pmfp_pkg::WORD_W:0]       trial;
    logic                            fits;

    assign trial = {r_rem, r_quo[pmfp_pkg::VALUE_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_zero  = r_zero;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        unique case (r_state)
            pmfp_pkg::DIV_IDLE: begin
                if (i_req.start) begin
                    n_state = pmfp_pkg::DIV_MUL;
                end
            end
            pmfp_pkg::DIV_MUL: begin
                n_div = i_req.divisor;
                n_rem = '0;
                n_cnt = '0;
                if (i_req.divisor == '0) begin
                    n_quo   = pmfp_pkg::VALUE_MAX;
                    n_zero  = 1'b1;
                    n_done  = 1'b1;
                    n_state = pmfp_pkg::DIV_IDLE;
                end else begin
                    n_quo   = pmfp_pkg::VALUE_W'(i_req.coeff) * pmfp_pkg::VALUE_W'(i_req.param);
                    n_zero  = 1'b0;
                    n_state = pmfp_pkg::DIV_STEP;
                end
            end
            pmfp_pkg::DIV_STEP: begin
                if (fits) begin
                    n_rem = pmfp_pkg::WORD_W'(trial - {1'b0, r_div});
                end else begin
                    n_rem = trial[pmfp_pkg::WORD_W-1:0];
                end
                n_quo = {r_quo[pmfp_pkg::VALUE_W-2:0], fits};
                n_cnt = r_cnt + pmfp_pkg::DIV_CNT_W'(1);
                if (r_cnt == pmfp_pkg::DIV_CNT_W'(pmfp_pkg::DIV_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = pmfp_pkg::DIV_IDLE;
                end
            end
            default: begin
                n_state = pmfp_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmfp_pkg::DIV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.zero     = r_zero;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- design/pmfp_checker.sv -----
// Port-level checker for the power meter frame parser, bound to the top level
`default_nettype none

`include "power_meter_frame_parser_macros.svh"

module pmfp_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [pmfp_pkg::STATUS_W-1:0]       i_frame_status,
    input  wire logic [pmfp_pkg::VALUE_W-1:0]        i_voltage_value,
    input  wire logic [pmfp_pkg::VALUE_W-1:0]        i_current_value,
    input  wire logic [pmfp_pkg::VALUE_W-1:0]        i_power_value
);

    `PMFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_frame_status) && $stable(i_power_value), "stalled result beat changed")

    `PMFP_ASSERT(a_status_code, i_clk, i_rst_n, !i_out_valid || i_frame_status == pmfp_pkg::STATUS_GOOD || i_frame_status == pmfp_pkg::STATUS_BAD_SUM || i_frame_status == pmfp_pkg::STATUS_ZERO_DIV, "unused frame status code")

    `PMFP_ASSERT(a_bad_sum_zero, i_clk, i_rst_n, !(i_out_valid && i_frame_status == pmfp_pkg::STATUS_BAD_SUM) || (i_voltage_value == '0 && i_current_value == '0 && i_power_value == '0), "checksum failure with nonzero values")

    `PMFP_ASSERT(a_zero_div_sat, i_clk, i_rst_n, !(i_out_valid && i_frame_status == pmfp_pkg::STATUS_ZERO_DIV) || i_voltage_value == pmfp_pkg::VALUE_MAX || i_current_value == pmfp_pkg::VALUE_MAX || i_power_value == pmfp_pkg::VALUE_MAX, "zero divisor without saturated value")

endmodule

bind power_meter_frame_parser pmfp_checker u_pmfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_frame_status  (o_frame_status),
    .i_voltage_value (o_voltage_value),
    .i_current_value (o_current_value),
    .i_power_value   (o_power_value)
);

`default_nettype wire
